### src/tpd_pkg.sv
// Package for the touch press debouncer: widths, register indexes, reset values,
// item and result types, and the byte-join helper. No dependencies.
package tpd_pkg;

   localparam int unsigned TimeWidth  = 32;
   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned ValWidth   = 11;
   localparam int unsigned CoordWidth = 12;
   localparam int unsigned DurWidth   = 16;
   localparam int unsigned CsrIdxWidth = 2;
   localparam int unsigned CsrDataWidth = 16;

   // configuration register indexes
   localparam logic [CsrIdxWidth-1:0] CSR_THRESHOLD   = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_PRESS_DEB   = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_RELEASE_DEB = 2'd2;

   localparam logic [ValWidth-1:0]   THRESHOLD_RST   = 11'd50;
   localparam logic [DurWidth-1:0]   PRESS_DEB_RST   = 16'd10;
   localparam logic [DurWidth-1:0]   RELEASE_DEB_RST = 16'd25;
   localparam logic [CoordWidth-1:0] COORD_NONE      = '1;

   typedef struct packed {
      logic [TimeWidth-1:0] now_ms;
      logic [ByteWidth-1:0] pressure_hi;
      logic [ByteWidth-1:0] pressure_lo;
      logic [ByteWidth-1:0] xpos_hi;
      logic [ByteWidth-1:0] xpos_lo;
      logic [ByteWidth-1:0] ypos_hi;
      logic [ByteWidth-1:0] ypos_lo;
   } item_type;

   typedef struct packed {
      logic                         is_pressed;
      logic signed [CoordWidth-1:0] xpos_out;
      logic signed [CoordWidth-1:0] ypos_out;
      logic [ValWidth-1:0]          pressure_out;
   } result_type;

   typedef struct packed {
      logic [ValWidth-1:0] pressure_threshold;
      logic [DurWidth-1:0] press_debounce_ms;
      logic [DurWidth-1:0] release_debounce_ms;
   } cfg_type;

   // (hi << 3) | lo, 11 bits
   function automatic logic [ValWidth-1:0] join_bytes(input logic [ByteWidth-1:0] hi,
                                                      input logic [ByteWidth-1:0] lo);
      join_bytes = {hi, 3'b000} | {3'b000, lo};
   endfunction

endpackage

### src/tpd_core.sv
// Debounce state machine, deadline timer and coordinate latches.
// Depends on tpd_pkg.
module tpd_core import tpd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  item_type   item,
   input  cfg_type    cfg,
   output result_type result
);

   typedef enum logic [1:0] {
      RELEASED    = 2'd0,
      PRESSED     = 2'd1,
      DEB_PRESS   = 2'd2,
      DEB_RELEASE = 2'd3
   } mode_type;

   mode_type               mode_ff, mode_in, mode_mid;
   logic [TimeWidth-1:0]   deadline_ff, deadline_in, deadline_mid;
   logic [CoordWidth-1:0]  x_ff, x_in, y_ff, y_in;
   logic [ValWidth-1:0]    pres;
   logic                   touched;
   logic [TimeWidth-1:0]   arm_sum, arm_val, elapsed;
   logic [DurWidth-1:0]    arm_dur;

   assign pres    = join_bytes(item.pressure_hi, item.pressure_lo);
   assign touched = pres > cfg.pressure_threshold;

   assign x_in = touched ? {1'b0, join_bytes(item.xpos_hi, item.xpos_lo)} : x_ff;
   assign y_in = touched ? {1'b0, join_bytes(item.ypos_hi, item.ypos_lo)} : y_ff;

   // only one of the two durations is ever armed per read
   assign arm_dur = (mode_ff == PRESSED) ? cfg.release_debounce_ms : cfg.press_debounce_ms;
   assign arm_sum = item.now_ms + {{(TimeWidth-DurWidth){1'b0}}, arm_dur};
   assign arm_val = (arm_sum == '0) ? TimeWidth'(1) : arm_sum;   // zero means no deadline

   always_comb begin
      mode_mid     = mode_ff;
      deadline_mid = deadline_ff;
      case (mode_ff)
         RELEASED: begin
            if (touched) begin
               mode_mid     = DEB_PRESS;
               deadline_mid = arm_val;
            end
         end
         PRESSED: begin
            if (!touched) begin
               mode_mid     = DEB_RELEASE;
               deadline_mid = arm_val;
            end
         end
         DEB_PRESS: begin
            if (!touched) begin
               mode_mid     = RELEASED;
               deadline_mid = '0;
            end
         end
         default: begin
            if (touched) begin
               mode_mid     = PRESSED;
               deadline_mid = '0;
            end
         end
      endcase
   end

   assign elapsed = item.now_ms - deadline_mid;

   always_comb begin
      mode_in     = mode_mid;
      deadline_in = deadline_mid;
      if (deadline_mid != '0 && !elapsed[TimeWidth-1]) begin
         deadline_in = '0;
         case (mode_mid)
            DEB_PRESS:   mode_in = PRESSED;
            DEB_RELEASE: mode_in = RELEASED;
            default:     mode_in = mode_mid;
         endcase
      end
   end

   assign result.is_pressed   = (mode_in == PRESSED);
   assign result.xpos_out     = x_in;
   assign result.ypos_out     = y_in;
   assign result.pressure_out = pres;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= RELEASED;
         deadline_ff <= '0;
         x_ff        <= COORD_NONE;
         y_ff        <= COORD_NONE;
      end else if (advance) begin
         mode_ff     <= mode_in;
         deadline_ff <= deadline_in;
         x_ff        <= x_in;
         y_ff        <= y_in;
      end
   end

endmodule

### src/touch_press_debouncer_top.sv
// Top level of the touch press debouncer: input register, config registers,
// result register. Depends on tpd_pkg and tpd_core.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid/req_ready    now_ms, pressure/xpos/ypos hi+lo bytes
//   rsp_      out        rsp_valid/rsp_ready    is_pressed, xpos_out, ypos_out, pressure_out
//   csr_      in         csr_valid/csr_ready    csr_index, csr_wdata
//
// One item per cycle sustained while rsp_ready holds; an accepted req passes through
// the input register and then the result register before rsp_valid rises.
// The loop that sets the rate is the debounce state update: one 32-bit deadline
// add and one 32-bit wrap-safe compare per item, closed combinationally.
// Reset: synchronous; state goes to released, no deadline, coordinates -1,
// registers to threshold 50, press 10 ms, release 25 ms.
// A stalled rsp holds the result register; the input register still takes one
// more item, after which req_ready drops. csr_ready is always high.
module touch_press_debouncer_top import tpd_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [TimeWidth-1:0]         req_now_ms,
   input  logic [ByteWidth-1:0]         req_pressure_hi,
   input  logic [ByteWidth-1:0]         req_pressure_lo,
   input  logic [ByteWidth-1:0]         req_xpos_hi,
   input  logic [ByteWidth-1:0]         req_xpos_lo,
   input  logic [ByteWidth-1:0]         req_ypos_hi,
   input  logic [ByteWidth-1:0]         req_ypos_lo,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_is_pressed,
   output logic signed [CoordWidth-1:0] rsp_xpos_out,
   output logic signed [CoordWidth-1:0] rsp_ypos_out,
   output logic [ValWidth-1:0]          rsp_pressure_out,
   // configuration channel
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CsrIdxWidth-1:0]       csr_index,
   input  logic [CsrDataWidth-1:0]      csr_wdata
);

   // input register
   logic       in_valid_ff, in_valid_in;
   item_type   item_ff;
   // result register
   logic       out_valid_ff, out_valid_in;
   result_type result_ff, result_in;
   // configuration registers
   cfg_type    cfg_ff;

   logic advance;     // item in input register moves through the core
   logic req_fire;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign in_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : ((rsp_ready) ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff.now_ms      <= req_now_ms;
         item_ff.pressure_hi <= req_pressure_hi;
         item_ff.pressure_lo <= req_pressure_lo;
         item_ff.xpos_hi     <= req_xpos_hi;
         item_ff.xpos_lo     <= req_xpos_lo;
         item_ff.ypos_hi     <= req_ypos_hi;
         item_ff.ypos_lo     <= req_ypos_lo;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   // config writes; an index past the list is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pressure_threshold  <= THRESHOLD_RST;
         cfg_ff.press_debounce_ms   <= PRESS_DEB_RST;
         cfg_ff.release_debounce_ms <= RELEASE_DEB_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_THRESHOLD:   cfg_ff.pressure_threshold  <= csr_wdata[ValWidth-1:0];
            CSR_PRESS_DEB:   cfg_ff.press_debounce_ms   <= csr_wdata;
            CSR_RELEASE_DEB: cfg_ff.release_debounce_ms <= csr_wdata;
            default: ;
         endcase
      end
   end

   tpd_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg_ff),
      .result  (result_in)
   );

   assign rsp_valid        = out_valid_ff;
   assign rsp_is_pressed   = result_ff.is_pressed;
   assign rsp_xpos_out     = result_ff.xpos_out;
   assign rsp_ypos_out     = result_ff.ypos_out;
   assign rsp_pressure_out = result_ff.pressure_out;

   // an item leaving the input register always lands in the result register
   a_advance_fills_out: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("item lost between input and result register");

   // input register never dropped while the result side is stalled
   a_in_holds: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("stalled item dropped from input register");

   // pressed implies a touch was seen, so coordinates are latched
   a_pressed_has_coord: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && result_ff.is_pressed) |->
         (result_ff.xpos_out != COORD_NONE && result_ff.ypos_out != COORD_NONE))
      else $error("pressed reported without latched coordinates");

   // reset leaves both the input and the result side empty
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!out_valid_ff && !in_valid_ff))
      else $error("valid flags not cleared by reset");

endmodule
